/* hdl/wrm_pkg.sv */
package wrm_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = SAMPLE_W + 1;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned SUM_W      = 43;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned RMS_W      = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned MAX_WINDOW  = 4096;
  localparam int unsigned LEN_RESET   = 1323;

  // one quotient bit per cycle, then one root bit per cycle
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS = RMS_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  // mean square never exceeds 2**30, so the root runs on the low 32 quotient bits
  localparam int unsigned ROOT_IN_W  = 2 * SQRT_STEPS;
  localparam int unsigned SREM_W     = RMS_W + 1;

  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic div_step;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } status_t;

endpackage

/* hdl/windowed_rms_meter.sv */
// A sample that leaves its window open frees the input once it has passed the capture,
//   square and accumulate states; a closing sample also runs the divide, square-root
//   and output states before its result shows. No new sample is taken until the last
//   is through, and a stalled result still holding the output register delays it more.
// Reset (rst_n low, synchronous): window length to 1323, accumulator and fill
//   count to zero, output empty.
module windowed_rms_meter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wrm_pkg::SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                           in_tlast,   // end_of_stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wrm_pkg::OUT_DATA_W-1:0] out_tdata,  // [15:0] rms_value, [28:16] window_samples
  input  logic                           cfg_we,
  input  logic [wrm_pkg::LEN_W-1:0]      cfg_wdata   // window_len
);

  wrm_pkg::cmd_t    cmd;
  wrm_pkg::status_t status;

  wrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wrm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

/* hdl/wrm_ctrl.sv */
module wrm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  wrm_pkg::status_t status,
  output wrm_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [wrm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (status.close) begin
          cnt_nxt   = wrm_pkg::CNT_W'(wrm_pkg::DIV_STEPS - 1);
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = wrm_pkg::CNT_W'(wrm_pkg::SQRT_STEPS - 1);
          state_nxt = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_OUT: begin
        // hold the result until the output register frees up
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* hdl/wrm_dp.sv */
module wrm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [wrm_pkg::SAMPLE_W-1:0]     in_tdata,
  input  logic                             in_tlast,
  input  logic                             cfg_we,
  input  logic [wrm_pkg::LEN_W-1:0]        cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wrm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wrm_pkg::cmd_t                    cmd,
  output wrm_pkg::status_t                 status
);

  localparam int unsigned CMP_W = (wrm_pkg::LEN_W > $clog2(wrm_pkg::MAX_WINDOW + 1)) ?
                                  wrm_pkg::LEN_W : $clog2(wrm_pkg::MAX_WINDOW + 1);

  logic [wrm_pkg::LEN_W-1:0]      len_r;
  logic [wrm_pkg::LEN_W-1:0]      eff_len;
  logic [wrm_pkg::MAG_W-1:0]      mag_r;
  logic                           last_r;
  logic [wrm_pkg::SQ_W-1:0]       sq_r;
  logic [wrm_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [wrm_pkg::LEN_W-1:0]      fill_r, fill_nxt;
  logic                           close;

  logic [wrm_pkg::SUM_W-1:0]      quo_r;
  logic [wrm_pkg::LEN_W-1:0]      divisor_r;
  logic [wrm_pkg::LEN_W-1:0]      drem_r;
  logic [wrm_pkg::LEN_W:0]        drem_t;
  logic                           dge;

  logic [wrm_pkg::SREM_W-1:0]     srem_r;
  logic [wrm_pkg::RMS_W-1:0]      root_r;
  logic [wrm_pkg::SREM_W+1:0]     srem_t;
  logic [wrm_pkg::SREM_W+1:0]     strial;
  logic                           sge;

  logic                           out_tvalid_r;
  logic [wrm_pkg::RMS_W-1:0]      rms_r;
  logic [wrm_pkg::LEN_W-1:0]      samples_r;

  // window length: zero acts as one, oversize saturates
  always_comb begin
    priority if (len_r == '0) begin
      eff_len = wrm_pkg::LEN_W'(1);
    end else if (CMP_W'(len_r) > CMP_W'(wrm_pkg::MAX_WINDOW)) begin
      eff_len = wrm_pkg::LEN_W'(wrm_pkg::MAX_WINDOW);
    end else begin
      eff_len = len_r;
    end
  end

  assign sum_nxt  = sum_r + wrm_pkg::SUM_W'(sq_r);
  assign fill_nxt = fill_r + 1'b1;
  assign close    = last_r || (fill_nxt >= eff_len);

  // restoring divide, one quotient bit per step
  assign drem_t = {drem_r, quo_r[wrm_pkg::SUM_W-1]};
  assign dge    = drem_t >= {1'b0, divisor_r};

  // digit-by-digit square root on two operand bits per step
  assign srem_t = {srem_r, quo_r[wrm_pkg::ROOT_IN_W-1 -: 2]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sge    = srem_t >= strial;

  assign status.close    = close;
  assign status.out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= wrm_pkg::LEN_W'(wrm_pkg::LEN_RESET);
      sum_r  <= '0;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (cmd.accum) begin
        if (close) begin
          sum_r  <= '0;
          fill_r <= '0;
        end else begin
          sum_r  <= sum_nxt;
          fill_r <= fill_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r  <= in_tdata[wrm_pkg::SAMPLE_W-1]
                ? wrm_pkg::MAG_W'(0) - {in_tdata[wrm_pkg::SAMPLE_W-1], in_tdata}
                : {1'b0, in_tdata};
      last_r <= in_tlast;
    end
    if (cmd.square) begin
      sq_r <= {{wrm_pkg::MAG_W{1'b0}}, mag_r} * {{wrm_pkg::MAG_W{1'b0}}, mag_r};
    end
    if (cmd.accum && close) begin
      quo_r     <= sum_nxt;
      divisor_r <= fill_nxt;
      drem_r    <= '0;
      srem_r    <= '0;
      root_r    <= '0;
    end
    if (cmd.div_step) begin
      drem_r <= dge ? wrm_pkg::LEN_W'(drem_t - {1'b0, divisor_r})
                    : wrm_pkg::LEN_W'(drem_t);
      quo_r  <= {quo_r[wrm_pkg::SUM_W-2:0], dge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sge ? wrm_pkg::SREM_W'(srem_t - strial) : wrm_pkg::SREM_W'(srem_t);
      root_r <= {root_r[wrm_pkg::RMS_W-2:0], sge};
      quo_r  <= {quo_r[wrm_pkg::SUM_W-3:0], 2'b00};
    end
    if (cmd.emit) begin
      rms_r     <= root_r;
      samples_r <= divisor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(wrm_pkg::OUT_DATA_W - wrm_pkg::LEN_W - wrm_pkg::RMS_W){1'b0}},
                       samples_r, rms_r};

  a_fill_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum && close |=> fill_r == '0 && sum_r == '0)
    else $error("accumulator not cleared after window close");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> divisor_r != '0)
    else $error("divide started with zero sample count");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> samples_r != '0)
    else $error("result carries zero window samples");

  a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> rms_r <= wrm_pkg::RMS_W'(32768))
    else $error("rms value above full scale");

endmodule
